[rtl/core/fir_filter_mac_core_assert.svh]
// ----------------------------------------------------------------------------
// FIR filter MAC core assertion macros
// Shared property macros for the checker of the filter core. The macros use
// the clk and rst_n signals of the scope in which they are expanded.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_MAC_CORE_ASSERT_SVH
`define FIR_FILTER_MAC_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fmac_pkg.sv]
// ----------------------------------------------------------------------------
// FIR filter MAC package
// Request codes, register map and control types shared by the filter core.
// ----------------------------------------------------------------------------
package fmac_pkg;

    // Request codes carried in the req_type field of an input word.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Register map: index of each register on the configuration port.
    localparam logic REG_TAP_COUNT = 1'b0;

    localparam int             TAP_COUNT_W     = 7;
    localparam logic [6:0]     TAP_COUNT_RESET = 7'd51;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;   // start a new sum
        logic issue;   // a tap read is issued to the stores this cycle
    } mac_ctl_t;

endpackage

[rtl/core/fmac_store.sv]
// ----------------------------------------------------------------------------
// FIR filter MAC storage array
// One write port and one registered read port. Entries that were never
// written since reset read as zero, tracked by one valid bit per entry.
// ----------------------------------------------------------------------------
module fmac_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_ok_reg ? rd_data_reg : '0;

endmodule

[rtl/core/fmac_mac.sv]
// ----------------------------------------------------------------------------
// FIR filter MAC arithmetic unit
// Registered multiplier feeding a wide accumulator, one tap per cycle, with
// rounding and saturation of the finished sum to the sample width.
// ----------------------------------------------------------------------------
module fmac_mac #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fmac_pkg::mac_ctl_t             ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] coef,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           busy,
    output logic signed [SAMPLE_WIDTH-1:0] result,
    output logic                           clipped
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int FRAC   = SW - 1;
    localparam int FULL_W = 2 * SW + $clog2(MAX_TAPS);
    // The accumulator is FULL_W bits wide, capped at 64, and wraps in two's complement.
    localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
    localparam int YW     = ACC_W - FRAC;
    localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);

    logic                      rd_valid_reg;
    logic                      prod_valid_reg;
    logic signed [2*SW-1:0]    prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic        [ACC_W-1:0]   sum_rnd;
    logic        [YW-1:0]      y;
    logic        [YW-SW:0]     y_hi;
    logic                      in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            rd_valid_reg   <= ctl.issue;
            prod_valid_reg <= rd_valid_reg;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_reg <= coef * sample;
        end
    end

    // Round half up, then floor by the fraction bits.
    assign sum_rnd  = acc_reg + HALF;
    assign y        = sum_rnd[ACC_W-1:FRAC];
    assign y_hi     = y[YW-1:SW-1];
    assign in_range = (y_hi == '0) || (y_hi == '1);

    always_comb
    begin
        if (in_range)
        begin
            result = y[SW-1:0];
        end
        else if (y[YW-1])
        begin
            result = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign clipped = !in_range;
    assign busy    = rd_valid_reg || prod_valid_reg;

endmodule

[rtl/core/fir_filter_mac_core.sv]
// ----------------------------------------------------------------------------
// FIR filter MAC core
// Direct-form FIR filter for one audio channel with a loadable coefficient
// store, a circular sample history and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                              Direction  Moves
//   -------  -----------------------------------  ---------  ------------------
//   in       in_valid, in_stall, req_type,        in         sample or coef word
//            coef_index, value
//   out      out_valid, out_stall,                out        filtered word
//            filtered_sample, saturated
//   config   psel, penable, pwrite, paddr,        in/out     tap_count register
//            pwdata, prdata, pready
//
// A coefficient word gives no result and leaves the block idle. A sample word
// holds the block busy while its taps are summed, where taps is tap_count
// limited to MAX_TAPS: the single multiply-accumulate unit handles one tap per
// cycle, and the store reads and the multiplier are registered ahead of the
// accumulator. The result sits in an output register, so a new word is taken
// while it waits; a finished sum is held back only while that register is
// full and stalled. Reset clears the stores (through per-entry valid bits),
// the history pointer and tap_count to 51, and takes effect at once.
// ----------------------------------------------------------------------------
module fir_filter_mac_core #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [5:0]                     coef_index,
    input  logic signed [SAMPLE_WIDTH-1:0] value,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
    output logic                           saturated,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (CNT_W > fmac_pkg::TAP_COUNT_W) ? CNT_W : fmac_pkg::TAP_COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [TAP_W-1:0]                ptr_reg, ptr_next;
    logic [TAP_W-1:0]                k_reg, k_next;
    logic [TAP_W-1:0]                slot_reg, slot_next;
    logic [CNT_W-1:0]                taps_reg, taps_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0]  out_data_reg, out_data_next;
    logic                            out_sat_reg, out_sat_next;
    logic [fmac_pkg::TAP_COUNT_W-1:0] tap_count_reg;

    logic                            in_accept;
    logic                            sample_accept;
    logic                            coef_write;
    logic                            cfg_write;
    logic [CMP_W-1:0]                tap_count_ext;
    logic [CNT_W-1:0]                taps_eff;
    logic                            last_tap;
    logic                            out_free;
    fmac_pkg::mac_ctl_t              mac_ctl;
    logic signed [SAMPLE_WIDTH-1:0]  coef_rd;
    logic signed [SAMPLE_WIDTH-1:0]  hist_rd;
    logic                            mac_busy;
    logic signed [SAMPLE_WIDTH-1:0]  mac_result;
    logic                            mac_clipped;

    // ------------------------------------------------------------------
    // Configuration port. Only tap_count exists; writes at other word
    // addresses are dropped and read back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fmac_pkg::TAP_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == fmac_pkg::REG_TAP_COUNT))
        begin
            tap_count_reg <= pwdata[fmac_pkg::TAP_COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == fmac_pkg::REG_TAP_COUNT) ?
                    32'(tap_count_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Input decode. The block takes a word only while the sequencer is idle.
    // ------------------------------------------------------------------
    assign in_stall      = (state_reg != S_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (req_type == fmac_pkg::REQ_SAMPLE);
    // Loads aimed beyond the end of the store are ignored.
    assign coef_write    = in_accept && (req_type == fmac_pkg::REQ_COEF) &&
                           (32'(coef_index) < 32'(MAX_TAPS));

    // A tap count larger than the store is limited to the store depth.
    assign tap_count_ext = CMP_W'(tap_count_reg);
    assign taps_eff      = (tap_count_ext > CMP_W'(MAX_TAPS)) ?
                           CNT_W'(MAX_TAPS) : CNT_W'(tap_count_ext);

    assign last_tap = ((CNT_W'(k_reg) + CNT_W'(1)) == taps_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Sequencer. On a sample the history slot is written, then one tap is
    // issued per cycle walking the coefficients up and the history back in
    // time. The drain state waits for the multiplier and accumulator to empty
    // and for the output register to be free, and hands the rounded sum to it.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        taps_next      = taps_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_accept)
                begin
                    k_next    = '0;
                    slot_next = ptr_reg;
                    taps_next = taps_eff;
                    ptr_next  = (ptr_reg == TAP_W'(MAX_TAPS - 1)) ?
                                '0 : ptr_reg + TAP_W'(1);
                    // With no taps in use the sum is simply zero.
                    state_next = (taps_eff == '0) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN:
            begin
                k_next    = k_reg + TAP_W'(1);
                slot_next = (slot_reg == '0) ?
                            TAP_W'(MAX_TAPS - 1) : slot_reg - TAP_W'(1);
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mac_result;
                    out_sat_next   = mac_clipped;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            k_reg         <= '0;
            slot_reg      <= '0;
            taps_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            slot_reg      <= slot_next;
            taps_reg      <= taps_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;
    assign saturated       = out_sat_reg;

    // ------------------------------------------------------------------
    // Coefficient store and sample history.
    // ------------------------------------------------------------------
    fmac_store #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_WIDTH)
    ) u_coef_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_write),
        .waddr (TAP_W'(coef_index)),
        .wdata (value),
        .raddr (k_reg),
        .rdata (coef_rd)
    );

    fmac_store #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_WIDTH)
    ) u_hist_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (sample_accept),
        .waddr (ptr_reg),
        .wdata (value),
        .raddr (slot_reg),
        .rdata (hist_rd)
    );

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit.
    // ------------------------------------------------------------------
    assign mac_ctl.clear = sample_accept;
    assign mac_ctl.issue = (state_reg == S_RUN);

    fmac_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .coef    (coef_rd),
        .sample  (hist_rd),
        .busy    (mac_busy),
        .result  (mac_result),
        .clipped (mac_clipped)
    );

endmodule

[rtl/core/fmac_checker.sv]
// ----------------------------------------------------------------------------
// FIR filter MAC port checker
// Watches the ports of the filter core over time and is bound to it below.
// ----------------------------------------------------------------------------
`include "fir_filter_mac_core_assert.svh"

module fmac_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           req_type,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
    input logic                           saturated
);

    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    // A stalled output word keeps its value.
    `FMAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filtered_sample) && $stable(saturated), "output word changed while stalled")

    // A sample keeps the block busy for at least the next cycle.
    `FMAC_ASSERT_NEXT(a_sample_busy, in_accept && (req_type == fmac_pkg::REQ_SAMPLE), in_stall, "block ready right after a sample")

    // After a coefficient load the block is ready again in the next cycle.
    `FMAC_ASSERT_NEXT(a_coef_quick, in_accept && (req_type == fmac_pkg::REQ_COEF), !in_stall, "block busy after a coefficient load")

    // A new result only appears at the end of a sample's computation.
    `FMAC_ASSERT_SAME(a_result_origin, $rose(out_valid), $past(in_stall), "result appeared while the block was idle")

endmodule

bind fir_filter_mac_core fmac_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fmac_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_sample (filtered_sample),
    .saturated       (saturated)
);
